// ===== hw/rtl/mfh_pkg.sv =====
package mfh_pkg;

    // Task index width and the number of tasks that may take the lock
    localparam int TASK_W = 4;
    localparam int TASK_COUNT = 16;
    localparam logic [TASK_W:0] TASK_LIMIT = (TASK_W + 1)'(TASK_COUNT);

    // Default number of wait queue entries
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int STATUS_W = 3;

    // Request kinds
    typedef enum logic {
        MODE_ACQUIRE = 1'b0,
        MODE_RELEASE = 1'b1
    } mode_t;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_OWNED     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_OWNER = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the request and read the queue head
        logic execute;   // apply the request and load the result register
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/mfh_ctrl.sv =====
module mfh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mfh_pkg::ctrl_cmd_t cmd
);
    import mfh_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // Result register may be loaded when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.execute = (state_reg == S_EXEC) && out_free;

    // Hold state and result valid; idle moves to execute on a request, execute returns once the result register is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/mfh_datapath.sv =====
module mfh_datapath #(
    parameter int QUEUE_DEPTH = mfh_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mfh_pkg::ctrl_cmd_t          cmd,
    input  logic                        mode,
    input  logic [mfh_pkg::TASK_W-1:0]  task_id,
    output logic [mfh_pkg::STATUS_W-1:0] status,
    output logic                        handoff,
    output logic [mfh_pkg::TASK_W-1:0]  new_owner,
    output logic                        lock_held,
    output logic [CNT_W-1:0]            waiting
);
    import mfh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Wait queue storage
    logic [TASK_W-1:0] queue_mem [QUEUE_DEPTH];

    // Latched request and queue head
    logic              req_mode_reg;
    logic [TASK_W-1:0] req_task_reg;
    logic [TASK_W-1:0] head_data_reg;

    // Lock state
    logic              locked_reg, locked_next;
    logic [TASK_W-1:0] owner_reg, owner_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;

    // Result register
    status_t           status_reg, status_next;
    logic              handoff_reg, handoff_next;
    logic [TASK_W-1:0] new_owner_reg;
    logic              lock_held_reg;
    logic [CNT_W-1:0]  waiting_reg;

    // Latch the request and read the oldest waiter
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_mode_reg  <= mode;
            req_task_reg  <= task_id;
            head_data_reg <= queue_mem[head_reg];
        end
    end

    // Enqueue a blocked requester at the tail
    always_ff @(posedge clk)
    begin
        if (cmd.execute && push)
        begin
            queue_mem[tail_reg] <= req_task_reg;
        end
    end

    // Decide the outcome of the latched request
    always_comb
    begin
        locked_next  = locked_reg;
        owner_next   = owner_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        status_next  = ST_NOT_OWNER;
        handoff_next = 1'b0;
        push         = 1'b0;
        if ({1'b0, req_task_reg} < TASK_LIMIT)
        begin
            if (req_mode_reg == MODE_ACQUIRE)
            begin
                if (locked_reg && (owner_reg == req_task_reg))
                begin
                    status_next = ST_OWNED;
                end
                else if (!locked_reg)
                begin
                    locked_next = 1'b1;
                    owner_next  = req_task_reg;
                    status_next = ST_GRANTED;
                end
                else if (count_reg == CNT_FULL)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    push        = 1'b1;
                    tail_next   = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                    status_next = ST_QUEUED;
                end
            end
            else
            begin
                if (!locked_reg || (owner_reg != req_task_reg))
                begin
                    status_next = ST_NOT_OWNER;
                end
                else if (count_reg != '0)
                begin
                    // pass the lock straight to the oldest waiter
                    owner_next   = head_data_reg;
                    head_next    = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    count_next   = count_reg - 1'b1;
                    handoff_next = 1'b1;
                    status_next  = ST_GRANTED;
                end
                else
                begin
                    owner_next  = '0;
                    locked_next = 1'b0;
                    status_next = ST_GRANTED;
                end
            end
        end
    end

    // Update lock state on execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            owner_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else if (cmd.execute)
        begin
            locked_reg <= locked_next;
            owner_reg  <= owner_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_next;
            handoff_reg   <= handoff_next;
            new_owner_reg <= locked_next ? owner_next : '0;
            lock_held_reg <= locked_next;
            waiting_reg   <= count_next;
        end
    end

    assign status    = status_reg;
    assign handoff   = handoff_reg;
    assign new_owner = new_owner_reg;
    assign lock_held = lock_held_reg;
    assign waiting   = waiting_reg;

endmodule

// ===== hw/rtl/mutex_fifo_handoff.sv =====
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   mode, task_id
// result    out        out_valid / out_ready status, handoff, new_owner, lock_held, waiting
//
// A request is handled in a capture step, which latches it and reads the wait
// queue head from its memory, then an execute step, which applies it and loads the result register.
// A new request is taken while the previous result still waits in the
// result register; a stalled result holds the request in the execute step.
// Reset leaves the lock free, the owner at zero and the wait queue empty.
module mutex_fifo_handoff #(
    parameter int QUEUE_DEPTH = mfh_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [mfh_pkg::TASK_W-1:0]   task_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mfh_pkg::STATUS_W-1:0] status,
    output logic                         handoff,
    output logic [mfh_pkg::TASK_W-1:0]   new_owner,
    output logic                         lock_held,
    output logic [CNT_W-1:0]             waiting
);
    import mfh_pkg::*;

    ctrl_cmd_t cmd;

    mfh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mfh_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mode      (mode),
        .task_id   (task_id),
        .status    (status),
        .handoff   (handoff),
        .new_owner (new_owner),
        .lock_held (lock_held),
        .waiting   (waiting)
    );

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (waiting <= CNT_W'(QUEUE_DEPTH)))
        else $error("wait count above queue depth");

    // A handoff always leaves the lock held and reports a grant
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && handoff) |-> (lock_held && (status == ST_GRANTED)))
        else $error("handoff without held lock");

    // Waiters and an owner exist only while the lock is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !lock_held) |-> (waiting == '0) && (new_owner == '0))
        else $error("free lock with waiters or owner");

    // One request in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

endmodule

// ===== test/mutex_fifo_handoff_tb.sv =====
`timescale 1ns / 100ps

module mutex_fifo_handoff_tb;

    import mfh_pkg::*;

    localparam int QDEPTH   = 16;
    localparam int CNT_W    = $clog2(QDEPTH + 1);
    localparam int RAND_REQ = 1200;

    typedef struct {
        mode_t            kind;
        logic [TASK_W-1:0] tid;
        bit               drain;
    } lock_request_t;

    typedef struct {
        status_t           status;
        logic              handoff;
        logic [TASK_W-1:0] new_owner;
        logic              lock_held;
        logic [CNT_W-1:0]  waiting;
    } lock_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   mode = 1'b0;
    logic [TASK_W-1:0]      task_id = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic                   handoff;
    logic [TASK_W-1:0]      new_owner;
    logic                   lock_held;
    logic [CNT_W-1:0]       waiting;

    // Requests waiting to be driven, and outcomes waiting to be seen
    lock_request_t          pending_requests[$];
    lock_outcome_t          outcomes_due[$];

    // Mirror of the mutex state, advanced on each accepted request
    logic                   lock_taken = 1'b0;
    logic [TASK_W-1:0]      lock_owner = '0;
    logic [TASK_W-1:0]      wait_line[QDEPTH];
    int                     line_head = 0;
    int                     line_tail = 0;
    int                     line_count = 0;

    // Owner followed by waiters, used only to steer the stimulus
    logic [TASK_W-1:0]      claim_line[$];

    int                     fail_count = 0;
    bit                     req_fire = 1'b0;
    int                     burst_left = 0;
    int                     gap_left = 0;
    int                     stall_mode = 0;
    int                     stall_left = 0;
    int                     stall_phase = 0;

    mutex_fifo_handoff #(
        .QUEUE_DEPTH (QDEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .task_id   (task_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .handoff   (handoff),
        .new_owner (new_owner),
        .lock_held (lock_held),
        .waiting   (waiting)
    );

    always #2 clk = ~clk;

    // Apply one request to the mirrored state and return what the block should show
    function automatic lock_outcome_t serve_request(mode_t kind, logic [TASK_W-1:0] tid);
        lock_outcome_t res;
        res.status  = ST_GRANTED;
        res.handoff = 1'b0;
        if ({1'b0, tid} >= TASK_LIMIT) begin
            res.status = ST_NOT_OWNER;
        end
        else if (kind == MODE_ACQUIRE) begin
            if (lock_taken && lock_owner == tid) begin
                res.status = ST_OWNED;
            end
            else if (!lock_taken) begin
                lock_taken = 1'b1;
                lock_owner = tid;
            end
            else if (line_count >= QDEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                wait_line[line_tail] = tid;
                line_tail = (line_tail + 1) % QDEPTH;
                line_count++;
                res.status = ST_QUEUED;
            end
        end
        else begin
            if (!lock_taken || lock_owner != tid) begin
                res.status = ST_NOT_OWNER;
            end
            else if (line_count != 0) begin
                // Hand the lock straight to the oldest waiter
                lock_owner = wait_line[line_head];
                line_head = (line_head + 1) % QDEPTH;
                line_count--;
                res.handoff = 1'b1;
            end
            else begin
                lock_taken = 1'b0;
                lock_owner = '0;
            end
        end
        res.new_owner = lock_taken ? lock_owner : '0;
        res.lock_held = lock_taken;
        res.waiting   = CNT_W'(line_count);
        return res;
    endfunction

    // Queue a request for the driver and track who holds and waits
    task automatic add_request(mode_t kind, logic [TASK_W-1:0] tid, bit drain);
        lock_request_t req;
        req.kind  = kind;
        req.tid   = tid;
        req.drain = drain;
        pending_requests.push_back(req);
        if (kind == MODE_ACQUIRE) begin
            if (claim_line.size() == 0) begin
                claim_line.push_back(tid);
            end
            else if (claim_line[0] != tid && claim_line.size() <= QDEPTH) begin
                claim_line.push_back(tid);
            end
        end
        else if (claim_line.size() > 0 && claim_line[0] == tid) begin
            void'(claim_line.pop_front());
        end
    endtask

    task automatic log_fault(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            log_fault($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Take requests and check results at the rising edge
    always @(posedge clk) begin
        lock_outcome_t want;
        req_fire = 1'b0;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                outcomes_due.push_back(serve_request(mode_t'(mode), task_id));
                req_fire = 1'b1;
            end
            if (out_valid && out_ready) begin
                if (outcomes_due.size() == 0) begin
                    log_fault("result with no request outstanding");
                end
                else begin
                    want = outcomes_due.pop_front();
                    check_field("status", int'(status), int'(want.status));
                    check_field("handoff", int'(handoff), int'(want.handoff));
                    check_field("new_owner", int'(new_owner), int'(want.new_owner));
                    check_field("lock_held", int'(lock_held), int'(want.lock_held));
                    check_field("waiting", int'(waiting), int'(want.waiting));
                end
            end
        end
    end

    // Drive requests in bursts with random gaps between them
    always @(negedge clk) begin
        lock_request_t req;
        logic          next_valid;
        next_valid = in_valid && !req_fire;
        if (rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end
            else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain && outcomes_due.size() != 0)) begin
                req = pending_requests.pop_front();
                mode    <= req.kind;
                task_id <= req.tid;
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end
                else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= next_valid;
    end

    // Stall the result side: always ready, random, or one cycle in eight
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (stall_phase % 8 == 0);
        endcase
    end

    initial begin
        int roll;
        int acq_weight;
        acq_weight = 50;

        // Release on a free lock, grant, re-acquire by the owner, foreign release
        add_request(MODE_RELEASE, 4'd0, 1'b0);
        add_request(MODE_ACQUIRE, 4'd0, 1'b0);
        add_request(MODE_ACQUIRE, 4'd0, 1'b0);
        add_request(MODE_RELEASE, 4'd5, 1'b0);
        // Fill the wait queue with one task queued over and over, then overflow it
        repeat (QDEPTH) add_request(MODE_ACQUIRE, 4'd15, 1'b0);
        add_request(MODE_ACQUIRE, 4'd3, 1'b0);
        // Hand over to the waiter, then from waiter to the next copy of itself
        add_request(MODE_RELEASE, 4'd0, 1'b0);
        add_request(MODE_RELEASE, 4'd15, 1'b0);

        // Random part: mostly owner releases and acquires, a little foreign noise
        for (int n = 0; n < RAND_REQ; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       acq_weight = 25;
                    1:       acq_weight = 50;
                    default: acq_weight = 85;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < acq_weight) begin
                add_request(MODE_ACQUIRE, 4'($urandom_range(0, 15)), n % 300 == 150);
            end
            else if (roll < 94 && claim_line.size() > 0) begin
                add_request(MODE_RELEASE, claim_line[0], n % 300 == 150);
            end
            else begin
                add_request(MODE_RELEASE, 4'($urandom_range(0, 15)), n % 300 == 150);
            end
        end

        // Hold reset, then release it at a falling edge, away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last request to drain, then let the pipeline settle
        while (pending_requests.size() != 0 || in_valid || outcomes_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0 && outcomes_due.size() == 0) begin
            $display("** mutex_fifo_handoff: PASSED **");
        end
        else begin
            $display("** mutex_fifo_handoff: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** mutex_fifo_handoff: FAILED **");
        $finish;
    end

endmodule
